// ===== hdl/websocket_frame_deframer_unit_macros.svh =====
// Assertion macros shared by the deframer modules.
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication, checked outside reset.
`define WSD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

// ===== hdl/wsd_pkg.sv =====
// Shared types and constants of the WebSocket frame deframer.
`default_nettype none

package wsd_pkg;

    localparam logic [3:0]  OP_TEXT       = 4'h1;
    localparam logic [3:0]  OP_CLOSE      = 4'h8;
    localparam logic [6:0]  LEN_CODE_16   = 7'd126;
    localparam logic [6:0]  LEN_CODE_64   = 7'd127;
    localparam logic [31:0] MAX_LEN_RESET = 32'd67108864;
    localparam int          QUEUE_DEPTH   = 4;

    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_EMPTY    = 2'd1,
        KIND_CLOSE    = 2'd2,
        KIND_OVERSIZE = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/wsd_parse.sv =====
// Front end: header parser, length check and payload unmasking, one byte per beat.
`default_nettype none

module wsd_parse (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             byte_valid,
    input  wire logic [7:0]       rx_byte,
    input  wire logic [31:0]      max_len,
    output wsd_pkg::result_t      res,
    output logic                  res_valid
);
    import wsd_pkg::*;
    `include "websocket_frame_deframer_unit_macros.svh"

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        fin_reg, fin_next;
    logic [3:0]  op_reg, op_next;
    logic        mask_reg, mask_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [63:0] len_reg, len_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  idx_reg, idx_next;
    logic        err_reg, err_next;

    logic        len_done;
    logic        start_pay;
    logic        end_frame;
    logic        end_empty;
    logic [63:0] len_val;
    logic [31:0] rem_dec;
    logic [7:0]  key_byte;
    logic [7:0]  plain;

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    assign plain   = rx_byte ^ key_byte;
    assign rem_dec = rem_reg - 32'd1;

    always_comb
    begin
        phase_next = phase_reg;
        fin_next   = fin_reg;
        op_next    = op_reg;
        mask_next  = mask_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        key_next   = key_reg;
        idx_next   = idx_reg;
        err_next   = err_reg;
        len_done   = 1'b0;
        start_pay  = 1'b0;
        end_frame  = 1'b0;
        end_empty  = 1'b0;
        len_val    = len_reg;
        res_valid  = 1'b0;
        res        = '{kind: KIND_BYTE, data: 8'd0, last: 1'b0};

        if (byte_valid && !err_reg)
        begin
            unique case (phase_reg)
                PH_HDR1:
                begin
                    mask_next = rx_byte[7];
                    len_next  = 64'd0;
                    if (rx_byte[6:0] == LEN_CODE_16)
                    begin
                        cnt_next   = 3'd1;
                        phase_next = PH_EXTLEN;
                    end
                    else if (rx_byte[6:0] == LEN_CODE_64)
                    begin
                        cnt_next   = 3'd7;
                        phase_next = PH_EXTLEN;
                    end
                    else
                    begin
                        len_val  = {57'd0, rx_byte[6:0]};
                        len_done = 1'b1;
                    end
                end
                PH_EXTLEN:
                begin
                    len_val  = {len_reg[55:0], rx_byte};
                    len_next = len_val;
                    if (cnt_reg != 3'd0)
                        cnt_next = cnt_reg - 3'd1;
                    else
                        len_done = 1'b1;
                end
                PH_MASK:
                begin
                    key_next = {key_reg[23:0], rx_byte};
                    if (cnt_reg != 3'd0)
                        cnt_next = cnt_reg - 3'd1;
                    else
                        start_pay = 1'b1;
                end
                PH_PAYLOAD:
                begin
                    idx_next = idx_reg + 2'd1;
                    rem_next = rem_dec;
                    if (fin_reg && op_reg == OP_TEXT)
                    begin
                        res_valid = 1'b1;
                        res       = '{kind: KIND_BYTE, data: plain, last: (rem_dec == 32'd0)};
                        if (rem_dec == 32'd0)
                            phase_next = PH_HDR0;
                    end
                    else if (rem_dec == 32'd0)
                    begin
                        end_frame = 1'b1;
                    end
                end
                default:
                begin
                    fin_next   = rx_byte[7];
                    op_next    = rx_byte[3:0];
                    phase_next = PH_HDR1;
                end
            endcase

            if (len_done)
            begin
                len_next = len_val;
                if (len_val[63:32] != 32'd0 || len_val[31:0] > max_len)
                begin
                    err_next  = 1'b1;
                    res_valid = 1'b1;
                    res       = '{kind: KIND_OVERSIZE, data: 8'd0, last: 1'b1};
                end
                else
                begin
                    key_next = 32'd0;
                    if (mask_next)
                    begin
                        cnt_next   = 3'd3;
                        phase_next = PH_MASK;
                    end
                    else
                    begin
                        start_pay = 1'b1;
                    end
                end
            end

            if (start_pay)
            begin
                rem_next = len_next[31:0];
                idx_next = 2'd0;
                if (len_next[31:0] == 32'd0)
                begin
                    end_frame = 1'b1;
                    end_empty = 1'b1;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end

            if (end_frame)
            begin
                phase_next = PH_HDR0;
                if (op_reg == OP_CLOSE)
                begin
                    res_valid = 1'b1;
                    res       = '{kind: KIND_CLOSE, data: 8'd0, last: 1'b1};
                end
                else if (end_empty && fin_reg && op_reg == OP_TEXT)
                begin
                    res_valid = 1'b1;
                    res       = '{kind: KIND_EMPTY, data: 8'd0, last: 1'b1};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR0;
            fin_reg   <= 1'b0;
            op_reg    <= 4'd0;
            mask_reg  <= 1'b0;
            cnt_reg   <= 3'd0;
            len_reg   <= 64'd0;
            rem_reg   <= 32'd0;
            key_reg   <= 32'd0;
            idx_reg   <= 2'd0;
            err_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            fin_reg   <= fin_next;
            op_reg    <= op_next;
            mask_reg  <= mask_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
            key_reg   <= key_next;
            idx_reg   <= idx_next;
            err_reg   <= err_next;
        end
    end

    `WSD_ASSERT_NXT(a_err_sticky, clk, rst_n, err_reg, err_reg)
    `WSD_ASSERT_IMP(a_pay_nonzero, clk, rst_n, phase_reg == PH_PAYLOAD, rem_reg != 32'd0)
    `WSD_ASSERT_IMP(a_event_shape, clk, rst_n, res_valid && res.kind != KIND_BYTE,
                    res.data == 8'd0 && res.last)

endmodule

`default_nettype wire

// ===== hdl/wsd_queue.sv =====
// Back end: short result queue between the parser and the result port.
`default_nettype none

module wsd_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire wsd_pkg::result_t wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output wsd_pkg::result_t      rd_data,
    output logic                  empty
);
    import wsd_pkg::*;
    `include "websocket_frame_deframer_unit_macros.svh"

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    result_t          mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (cnt_reg == DEPTH_C);
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_wr)
            wptr_next = (wptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        if (do_rd)
            rptr_next = (rptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    `WSD_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= DEPTH_C)
    `WSD_ASSERT_NXT(a_cnt_inc, clk, rst_n, do_wr && !do_rd, cnt_reg == $past(cnt_reg) + 1'b1)
    `WSD_ASSERT_NXT(a_cnt_dec, clk, rst_n, do_rd && !do_wr, cnt_reg == $past(cnt_reg) - 1'b1)

endmodule

`default_nettype wire

// ===== hdl/websocket_frame_deframer_unit.sv =====
// Top level of the WebSocket frame deframer: parser front end and result queue.
//
// Usage:
//  Input channel: drive rx_byte and raise push; a byte is taken at a clock edge
//  where push is high and full is low. One byte per beat, every cycle while full is low.
//  Result channel: while empty is low, result_kind, data_byte and last_of_message
//  show the oldest result; it is taken at an edge where pop is high.
//  Config channel: cfg_data carries the payload length limit, written when
//  cfg_valid and cfg_ready are high; cfg_ready is always high. Write it idle.
//  Latency: a result enters the queue the cycle after its byte, behind any older results.
//  Throughput: one byte per cycle while full is low; header decode, the length
//  compare and the unmask XOR all finish in the parser in the cycle the byte is taken.
//  Stall: a four-entry result queue absorbs a stalled receiver; full rises
//  when it fills and holds off input until a result is popped.
//  Reset: parser returns to the first header byte, the sticky oversize error
//  clears, the queue empties and the limit returns to 64 MiB.
`default_nettype none

module websocket_frame_deframer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  rx_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       result_kind,
    output logic [7:0]       data_byte,
    output logic             last_of_message,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);
    import wsd_pkg::*;

    logic [31:0] max_len_reg;
    logic        byte_acc;
    logic        res_valid;
    result_t     res;
    result_t     head;

    assign cfg_ready = 1'b1;
    assign byte_acc  = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAX_LEN_RESET;
        else if (cfg_valid && cfg_ready)
            max_len_reg <= cfg_data;
    end

    wsd_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_acc),
        .rx_byte    (rx_byte),
        .max_len    (max_len_reg),
        .res        (res),
        .res_valid  (res_valid)
    );

    wsd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .full    (full),
        .rd_en   (pop),
        .rd_data (head),
        .empty   (empty)
    );

    assign result_kind     = head.kind;
    assign data_byte       = head.data;
    assign last_of_message = head.last;

endmodule

`default_nettype wire
